@@ design/qcr_pkg.sv @@
// Shared constants, types and helper functions of the quaternion compose and renormalize block.
package qcr_pkg;

    localparam int COMP_WIDTH = 32;
    localparam int FRAC_BITS  = 29;
    localparam int MODE_WIDTH = 2;
    localparam int CNT_WIDTH  = 10;
    localparam logic [CNT_WIDTH-1:0] RENORM_RESET = CNT_WIDTH'(50);

    localparam logic [MODE_WIDTH-1:0] MODE_LOAD = 2'd0;
    localparam logic [MODE_WIDTH-1:0] MODE_PRE  = 2'd1;
    localparam logic [MODE_WIDTH-1:0] MODE_POST = 2'd2;
    localparam logic [MODE_WIDTH-1:0] MODE_NORM = 2'd3;

    // One Hamilton product term: operand indexes (x, y, z, w) and sign.
    typedef struct packed {
        logic [1:0] ai;
        logic [1:0] bi;
        logic       neg;
    } term_t;

    // Term k of component c for r = a * b.
    function automatic term_t term_info(input logic [3:0] t);
        term_t r;
        case (t)
            4'd0:    r = '{ai: 2'd3, bi: 2'd0, neg: 1'b0};
            4'd1:    r = '{ai: 2'd0, bi: 2'd3, neg: 1'b0};
            4'd2:    r = '{ai: 2'd1, bi: 2'd2, neg: 1'b0};
            4'd3:    r = '{ai: 2'd2, bi: 2'd1, neg: 1'b1};
            4'd4:    r = '{ai: 2'd3, bi: 2'd1, neg: 1'b0};
            4'd5:    r = '{ai: 2'd1, bi: 2'd3, neg: 1'b0};
            4'd6:    r = '{ai: 2'd2, bi: 2'd0, neg: 1'b0};
            4'd7:    r = '{ai: 2'd0, bi: 2'd2, neg: 1'b1};
            4'd8:    r = '{ai: 2'd3, bi: 2'd2, neg: 1'b0};
            4'd9:    r = '{ai: 2'd2, bi: 2'd3, neg: 1'b0};
            4'd10:   r = '{ai: 2'd0, bi: 2'd1, neg: 1'b0};
            4'd11:   r = '{ai: 2'd1, bi: 2'd0, neg: 1'b1};
            4'd12:   r = '{ai: 2'd3, bi: 2'd3, neg: 1'b0};
            4'd13:   r = '{ai: 2'd0, bi: 2'd0, neg: 1'b1};
            4'd14:   r = '{ai: 2'd1, bi: 2'd1, neg: 1'b1};
            default: r = '{ai: 2'd2, bi: 2'd2, neg: 1'b1};
        endcase
        return r;
    endfunction

    // Magnitude of a signed component as an unsigned value.
    function automatic logic [COMP_WIDTH-1:0] mag(input logic [COMP_WIDTH-1:0] c);
        return c[COMP_WIDTH-1] ? (~c + COMP_WIDTH'(1)) : c;
    endfunction

endpackage

@@ design/qcr_cmd_if.sv @@
// Request channel carrying the mode and argument quaternion.
interface qcr_cmd_if import qcr_pkg::*; ();
    logic                         valid;
    logic                         ready;
    logic [MODE_WIDTH-1:0]        mode;
    logic signed [COMP_WIDTH-1:0] arg_x;
    logic signed [COMP_WIDTH-1:0] arg_y;
    logic signed [COMP_WIDTH-1:0] arg_z;
    logic signed [COMP_WIDTH-1:0] arg_w;

    modport source (output valid, mode, arg_x, arg_y, arg_z, arg_w, input ready);
    modport sink   (input valid, mode, arg_x, arg_y, arg_z, arg_w, output ready);
endinterface

@@ design/qcr_rsp_if.sv @@
// Response channel carrying the updated quaternion and flags.
interface qcr_rsp_if import qcr_pkg::*; ();
    logic                         valid;
    logic                         ready;
    logic signed [COMP_WIDTH-1:0] res_x;
    logic signed [COMP_WIDTH-1:0] res_y;
    logic signed [COMP_WIDTH-1:0] res_z;
    logic signed [COMP_WIDTH-1:0] res_w;
    logic                         renormalized;
    logic                         zero_norm;
    logic                         saturated;

    modport source (output valid, res_x, res_y, res_z, res_w, renormalized, zero_norm,
                    saturated, input ready);
    modport sink   (input valid, res_x, res_y, res_z, res_w, renormalized, zero_norm,
                    saturated, output ready);
endinterface

@@ design/quaternion_compose_renorm_top.sv @@
// Quaternion compose and renormalize block: sequencer around one shared multiplier.
//
// Usage: requests arrive on cmd (mode plus argument quaternion, Q2.29), each
// request gives exactly one response on rsp with the stored quaternion after
// the operation and the renormalized, zero_norm and saturated flags.
// cfg_we/cfg_wdata write renorm_interval; write only while the block is idle.
// cmd.ready is high only while the sequencer is idle; one request at a time.
// Work per request:
//   load:                 stores the argument quaternion
//   multiply only:        16 products through the one multiplier
//   normalize:            sum of squares, one root bit a cycle, then one
//                         quotient bit a cycle per component
//   counted multiply + normalize: the multiply, then the normalize
//   zero quaternion normalize: ends after the sum of squares
// A finished response sits in an output register; the next request is taken
// while it waits. If rsp stalls, a second finished result holds in the
// sequencer until the register frees. Reset clears the quaternion, the
// compose count and sets renorm_interval to 50.
module quaternion_compose_renorm_top
    import qcr_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    qcr_cmd_if.sink              cmd,
    qcr_rsp_if.source            rsp,
    input  logic                 cfg_we,
    input  logic [CNT_WIDTH-1:0] cfg_wdata
);

    localparam int CW     = COMP_WIDTH;
    localparam int MW     = CW + 1;
    localparam int PW     = 2 * MW;
    localparam int AW     = 2 * CW + 3;
    localparam int SW     = 2 * CW + 2;
    localparam int RTW    = CW + 1;
    localparam int RW     = CW + 4;
    localparam int DN     = CW + FRAC_BITS;
    localparam int CTW    = $clog2(DN + 2);
    localparam logic signed [AW-1:0] ONE_A = AW'(1);
    localparam logic signed [AW-1:0] HALF  = ONE_A <<< (FRAC_BITS - 1);
    localparam logic signed [AW-1:0] MAXV  = (ONE_A <<< (CW - 1)) - ONE_A;
    localparam logic signed [AW-1:0] MINV  = -(ONE_A <<< (CW - 1));
    localparam logic [DN-1:0] LIM_NEG = DN'(1) << (CW - 1);
    localparam logic [DN-1:0] LIM_POS = LIM_NEG - DN'(1);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_MUL  = 6'b000010,
        S_SQ   = 6'b000100,
        S_SQRT = 6'b001000,
        S_DIV  = 6'b010000,
        S_DONE = 6'b100000
    } state_t;

    state_t                 state_reg, state_next;
    logic [CTW-1:0]         cnt_reg, cnt_next;
    logic [1:0]             ci_reg, ci_next;
    logic [MODE_WIDTH-1:0]  mode_reg, mode_next;
    logic [CW-1:0]          q_reg [4];
    logic [CW-1:0]          q_next [4];
    logic [CW-1:0]          arg_reg [4];
    logic [CW-1:0]          arg_next [4];
    logic [CW-1:0]          p_reg [3];
    logic [CW-1:0]          p_next [3];
    logic signed [PW-1:0]   prod_reg;
    logic                   neg_reg, neg_next;
    logic signed [AW-1:0]   acc_reg, acc_next;
    logic [SW-1:0]          m_reg, m_next;
    logic [RTW-1:0]         root_reg, root_next;
    logic [RW-1:0]          rem_reg, rem_next;
    logic [DN-1:0]          dvd_reg, dvd_next;
    logic [DN-1:0]          quo_reg, quo_next;
    logic [CNT_WIDTH-1:0]   count_reg, count_next;
    logic [CNT_WIDTH-1:0]   interval_reg;
    logic                   norm_req_reg, norm_req_next;
    logic                   sat_reg, sat_next;
    logic                   renorm_reg, renorm_next;
    logic                   zero_reg, zero_next;
    logic                   ovalid_reg, ovalid_next;
    logic [CW-1:0]          ores_reg [4];
    logic [CW-1:0]          ores_next [4];
    logic                   oren_reg, oren_next;
    logic                   ozero_reg, ozero_next;
    logic                   osat_reg, osat_next;

    logic signed [MW-1:0]   ma, mb;
    term_t                  term;
    logic signed [AW-1:0]   prod_ext, acc_sum, rsum, rv;
    logic [CW-1:0]          rclip;
    logic                   rsat;
    logic [RW-1:0]          sq_shift, sq_trial;
    logic [RW-1:0]          dv_shift;
    logic [CNT_WIDTH:0]     count_inc;
    logic [SW-1:0]          m_sum;
    logic [DN-1:0]          lim;

    assign cmd.ready        = state_reg[0];
    assign rsp.valid        = ovalid_reg;
    assign rsp.res_x        = ores_reg[0];
    assign rsp.res_y        = ores_reg[1];
    assign rsp.res_z        = ores_reg[2];
    assign rsp.res_w        = ores_reg[3];
    assign rsp.renormalized = oren_reg;
    assign rsp.zero_norm    = ozero_reg;
    assign rsp.saturated    = osat_reg;

    // Select multiplier operands for the current product
    always_comb
    begin
        term = term_info(cnt_reg[3:0]);
        ma   = '0;
        mb   = '0;
        if (state_reg == S_SQ)
        begin
            ma = $signed({1'b0, mag(q_reg[cnt_reg[1:0]])});
            mb = ma;
        end
        else if (mode_reg == MODE_PRE)
        begin
            ma = $signed({arg_reg[term.ai][CW-1], arg_reg[term.ai]});
            mb = $signed({q_reg[term.bi][CW-1], q_reg[term.bi]});
        end
        else
        begin
            ma = $signed({q_reg[term.ai][CW-1], q_reg[term.ai]});
            mb = $signed({arg_reg[term.bi][CW-1], arg_reg[term.bi]});
        end
    end

    // Accumulate signed terms and round/clip a finished component
    always_comb
    begin
        prod_ext = AW'(prod_reg);
        acc_sum  = neg_reg ? (acc_reg - prod_ext) : (acc_reg + prod_ext);
        rsum     = acc_sum + HALF;
        rv       = rsum >>> FRAC_BITS;
        rsat     = 1'b0;
        rclip    = rv[CW-1:0];
        if (rv > MAXV)
        begin
            rsat  = 1'b1;
            rclip = MAXV[CW-1:0];
        end
        else if (rv < MINV)
        begin
            rsat  = 1'b1;
            rclip = MINV[CW-1:0];
        end
    end

    // Shared shift and trial compare for root and quotient steps
    assign sq_shift  = {rem_reg[RW-3:0], m_reg[SW-1:SW-2]};
    assign sq_trial  = RW'({root_reg, 2'b01});
    assign dv_shift  = {rem_reg[RW-2:0], dvd_reg[DN-1]};
    assign count_inc = {1'b0, count_reg} + (CNT_WIDTH + 1)'(1);
    assign m_sum     = m_reg + SW'(prod_reg);
    assign lim       = q_reg[ci_reg][CW-1] ? LIM_NEG : LIM_POS;

    // Sequencer
    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        ci_next       = ci_reg;
        mode_next     = mode_reg;
        q_next        = q_reg;
        arg_next      = arg_reg;
        p_next        = p_reg;
        neg_next      = neg_reg;
        acc_next      = acc_reg;
        m_next        = m_reg;
        root_next     = root_reg;
        rem_next      = rem_reg;
        dvd_next      = dvd_reg;
        quo_next      = quo_reg;
        count_next    = count_reg;
        norm_req_next = norm_req_reg;
        sat_next      = sat_reg;
        renorm_next   = renorm_reg;
        zero_next     = zero_reg;
        ovalid_next   = ovalid_reg;
        ores_next     = ores_reg;
        oren_next     = oren_reg;
        ozero_next    = ozero_reg;
        osat_next     = osat_reg;

        // drop the response once taken
        if (rsp.ready)
        begin
            ovalid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd.valid)
                begin
                    mode_next     = cmd.mode;
                    arg_next[0]   = cmd.arg_x;
                    arg_next[1]   = cmd.arg_y;
                    arg_next[2]   = cmd.arg_z;
                    arg_next[3]   = cmd.arg_w;
                    sat_next      = 1'b0;
                    renorm_next   = 1'b0;
                    zero_next     = 1'b0;
                    norm_req_next = 1'b0;
                    cnt_next      = '0;
                    acc_next      = '0;
                    m_next        = '0;
                    unique case (cmd.mode)
                        MODE_LOAD:
                        begin
                            q_next[0]  = cmd.arg_x;
                            q_next[1]  = cmd.arg_y;
                            q_next[2]  = cmd.arg_z;
                            q_next[3]  = cmd.arg_w;
                            state_next = S_DONE;
                        end
                        MODE_PRE:
                        begin
                            if (count_inc > {1'b0, interval_reg})
                            begin
                                count_next    = '0;
                                norm_req_next = 1'b1;
                            end
                            else
                            begin
                                count_next = count_inc[CNT_WIDTH-1:0];
                            end
                            state_next = S_MUL;
                        end
                        MODE_POST:
                        begin
                            state_next = S_MUL;
                        end
                        default:
                        begin
                            state_next = S_SQ;
                        end
                    endcase
                end
            end

            S_MUL:
            begin
                neg_next = term.neg;
                cnt_next = cnt_reg + CTW'(1);
                if (cnt_reg != '0)
                begin
                    if (cnt_reg[1:0] == 2'd0)
                    begin
                        acc_next = '0;
                        sat_next = sat_reg | rsat;
                        if (cnt_reg[4])
                        begin
                            q_next[0] = p_reg[0];
                            q_next[1] = p_reg[1];
                            q_next[2] = p_reg[2];
                            q_next[3] = rclip;
                            cnt_next  = '0;
                            state_next = norm_req_reg ? S_SQ : S_DONE;
                        end
                        else
                        begin
                            p_next[cnt_reg[3:2] - 2'd1] = rclip;
                        end
                    end
                    else
                    begin
                        acc_next = acc_sum;
                    end
                end
            end

            S_SQ:
            begin
                cnt_next = cnt_reg + CTW'(1);
                if (cnt_reg != '0)
                begin
                    m_next = m_sum;
                end
                if (cnt_reg == CTW'(4))
                begin
                    cnt_next  = '0;
                    root_next = '0;
                    rem_next  = '0;
                    if (m_sum == '0)
                    begin
                        zero_next  = 1'b1;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_SQRT;
                    end
                end
            end

            S_SQRT:
            begin
                // one root bit per cycle
                m_next   = m_reg << 2;
                cnt_next = cnt_reg + CTW'(1);
                if (sq_shift >= sq_trial)
                begin
                    rem_next  = sq_shift - sq_trial;
                    root_next = {root_reg[RTW-2:0], 1'b1};
                end
                else
                begin
                    rem_next  = sq_shift;
                    root_next = {root_reg[RTW-2:0], 1'b0};
                end
                if (cnt_reg == CTW'(RTW - 1))
                begin
                    cnt_next   = '0;
                    ci_next    = '0;
                    state_next = S_DIV;
                end
            end

            S_DIV:
            begin
                if (cnt_reg == '0)
                begin
                    dvd_next = DN'(mag(q_reg[ci_reg])) << FRAC_BITS;
                    rem_next = '0;
                    quo_next = '0;
                    cnt_next = CTW'(1);
                end
                else if (cnt_reg <= CTW'(DN))
                begin
                    // one quotient bit per cycle
                    dvd_next = dvd_reg << 1;
                    cnt_next = cnt_reg + CTW'(1);
                    if (dv_shift >= RW'(root_reg))
                    begin
                        rem_next = dv_shift - RW'(root_reg);
                        quo_next = {quo_reg[DN-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_next = dv_shift;
                        quo_next = {quo_reg[DN-2:0], 1'b0};
                    end
                end
                else
                begin
                    if (quo_reg > lim)
                    begin
                        sat_next = 1'b1;
                        q_next[ci_reg] = q_reg[ci_reg][CW-1] ? (~lim[CW-1:0] + CW'(1))
                                                             : lim[CW-1:0];
                    end
                    else
                    begin
                        q_next[ci_reg] = q_reg[ci_reg][CW-1] ? (~quo_reg[CW-1:0] + CW'(1))
                                                             : quo_reg[CW-1:0];
                    end
                    cnt_next = '0;
                    ci_next  = ci_reg + 2'd1;
                    if (ci_reg == 2'd3)
                    begin
                        renorm_next = 1'b1;
                        state_next  = S_DONE;
                    end
                end
            end

            S_DONE:
            begin
                // hold until the output register is free
                if (!ovalid_reg || rsp.ready)
                begin
                    ovalid_next = 1'b1;
                    ores_next   = q_reg;
                    oren_next   = renorm_reg;
                    ozero_next  = zero_reg;
                    osat_next   = sat_reg;
                    state_next  = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            cnt_reg      <= '0;
            ci_reg       <= '0;
            mode_reg     <= MODE_LOAD;
            q_reg        <= '{default: '0};
            count_reg    <= '0;
            interval_reg <= RENORM_RESET;
            norm_req_reg <= 1'b0;
            sat_reg      <= 1'b0;
            renorm_reg   <= 1'b0;
            zero_reg     <= 1'b0;
            ovalid_reg   <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            ci_reg       <= ci_next;
            mode_reg     <= mode_next;
            q_reg        <= q_next;
            count_reg    <= count_next;
            norm_req_reg <= norm_req_next;
            sat_reg      <= sat_next;
            renorm_reg   <= renorm_next;
            zero_reg     <= zero_next;
            ovalid_reg   <= ovalid_next;
            if (cfg_we)
            begin
                interval_reg <= cfg_wdata;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        arg_reg   <= arg_next;
        p_reg     <= p_next;
        prod_reg  <= ma * mb;
        neg_reg   <= neg_next;
        acc_reg   <= acc_next;
        m_reg     <= m_next;
        root_reg  <= root_next;
        rem_reg   <= rem_next;
        dvd_reg   <= dvd_next;
        quo_reg   <= quo_next;
        ores_reg  <= ores_next;
        oren_reg  <= oren_next;
        ozero_reg <= ozero_next;
        osat_reg  <= osat_next;
    end

    // A normalization never both succeeds and meets a zero quaternion
    a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> !(rsp.renormalized && rsp.zero_norm))
        else $error("renormalized and zero_norm both set");

    // An accepted request leaves idle
    a_leave_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.valid && cmd.ready) |=> (state_reg != S_IDLE))
        else $error("sequencer stayed idle after accept");

    // A finished result waits while the output register is stalled
    a_done_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && ovalid_reg && !rsp.ready) |=> (state_reg == S_DONE))
        else $error("result dropped under stall");

    // A load never reports saturation or renormalization
    a_load_nosat: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && mode_reg == MODE_LOAD) |-> (!sat_reg && !renorm_reg))
        else $error("flags set on load");

endmodule

@@ dv/qcr_tb_ifs.sv @@
// Testbench package: record of one expected response.
package qcr_tb_pkg;
    import qcr_pkg::*;

    // One expected response of the block.
    typedef struct {
        logic signed [COMP_WIDTH-1:0] x;
        logic signed [COMP_WIDTH-1:0] y;
        logic signed [COMP_WIDTH-1:0] z;
        logic signed [COMP_WIDTH-1:0] w;
        logic                         renormalized;
        logic                         zero_norm;
        logic                         saturated;
    } quat_rsp_t;
endpackage

@@ dv/qcr_checker.sv @@
// Checker: watches request, response and register write, predicts and compares.
module qcr_checker
    import qcr_pkg::*;
    import qcr_tb_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    qcr_cmd_if                   cmd,
    qcr_rsp_if                   rsp,
    input  logic                 cfg_we,
    input  logic [CNT_WIDTH-1:0] cfg_wdata,
    output int                   fail_count,
    output int                   pending
);

    logic signed [COMP_WIDTH-1:0] orient [4];
    logic [CNT_WIDTH-1:0]         count_q;
    logic [CNT_WIDTH-1:0]         interval_q;
    quat_rsp_t                    expected_q [$];

    localparam logic signed [COMP_WIDTH-1:0] MAXC = {1'b0, {(COMP_WIDTH-1){1'b1}}};
    localparam logic signed [COMP_WIDTH-1:0] MINC = {1'b1, {(COMP_WIDTH-1){1'b0}}};

    // Round once to the fraction width, then clip to the component range.
    function automatic logic signed [COMP_WIDTH-1:0] round_clip(
        input logic signed [127:0] acc, inout logic sat);
        logic signed [127:0] v;
        v = (acc + (128'sd1 <<< (FRAC_BITS-1))) >>> FRAC_BITS;
        if (v > 128'(MAXC)) begin sat = 1'b1; return MAXC; end
        if (v < 128'(MINC)) begin sat = 1'b1; return MINC; end
        return v[COMP_WIDTH-1:0];
    endfunction

    // Hamilton product r = a * b, components x, y, z, w.
    function automatic void hamilton(input logic signed [COMP_WIDTH-1:0] a [4],
        input logic signed [COMP_WIDTH-1:0] b [4],
        output logic signed [COMP_WIDTH-1:0] r [4], inout logic sat);
        logic signed [127:0] p [4][4];
        for (int i = 0; i < 4; i++)
            for (int j = 0; j < 4; j++)
                p[i][j] = 128'(a[i]) * 128'(b[j]);
        r[0] = round_clip(p[3][0] + p[0][3] + p[1][2] - p[2][1], sat);
        r[1] = round_clip(p[3][1] + p[1][3] + p[2][0] - p[0][2], sat);
        r[2] = round_clip(p[3][2] + p[2][3] + p[0][1] - p[1][0], sat);
        r[3] = round_clip(p[3][3] - p[0][0] - p[1][1] - p[2][2], sat);
    endfunction

    // Scale to unit length: exact sum of squares, integer root, truncating divide.
    function automatic void unit_scale(inout logic signed [COMP_WIDTH-1:0] q [4],
        inout logic ren, inout logic zer, inout logic sat);
        logic [127:0] m, s, t, a, quo, lim;
        m = '0;
        s = '0;
        for (int i = 0; i < 4; i++)
        begin
            a = q[i] < 0 ? 128'(-65'(q[i])) : 128'(q[i]);
            m += a * a;
        end
        if (m == 0)
        begin
            zer = 1'b1;
            return;
        end
        for (int b = 63; b >= 0; b--)
        begin
            t = s | (128'd1 << b);
            if (t * t <= m) s = t;
        end
        for (int i = 0; i < 4; i++)
        begin
            a = q[i] < 0 ? 128'(-65'(q[i])) : 128'(q[i]);
            lim = q[i] < 0 ? (128'd1 << (COMP_WIDTH-1)) : 128'(MAXC);
            quo = (a << FRAC_BITS) / s;
            if (quo > lim)
            begin
                sat = 1'b1;
                quo = lim;
            end
            q[i] = q[i] < 0 ? -quo[COMP_WIDTH-1:0] : quo[COMP_WIDTH-1:0];
        end
        ren = 1'b1;
    endfunction

    assign pending = expected_q.size();

    // Predict on accepted requests, compare on accepted responses.
    always @(posedge clk or negedge rst_n)
    begin
        logic signed [COMP_WIDTH-1:0] arg [4];
        logic signed [COMP_WIDTH-1:0] prod [4];
        logic ren, zer, sat;
        quat_rsp_t e;
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++) orient[i] = '0;
            count_q    = '0;
            interval_q = RENORM_RESET;
            fail_count = 0;
            expected_q.delete();
        end
        else
        begin
            if (cfg_we) interval_q = cfg_wdata;
            if (cmd.valid && cmd.ready)
            begin
                arg = '{cmd.arg_x, cmd.arg_y, cmd.arg_z, cmd.arg_w};
                ren = 1'b0;
                zer = 1'b0;
                sat = 1'b0;
                case (cmd.mode)
                    MODE_LOAD: orient = arg;
                    MODE_PRE:
                    begin
                        hamilton(arg, orient, prod, sat);
                        orient = prod;
                        if (32'(count_q) + 1 > 32'(interval_q))
                        begin
                            count_q = '0;
                            unit_scale(orient, ren, zer, sat);
                        end
                        else
                            count_q = count_q + 1'b1;
                    end
                    MODE_POST:
                    begin
                        hamilton(orient, arg, prod, sat);
                        orient = prod;
                    end
                    default: unit_scale(orient, ren, zer, sat);
                endcase
                e = '{orient[0], orient[1], orient[2], orient[3], ren, zer, sat};
                expected_q.push_back(e);
            end
            if (rsp.valid && rsp.ready)
            begin
                if (expected_q.size() == 0)
                begin
                    $error("response with nothing expected");
                    fail_count++;
                end
                else
                begin
                    e = expected_q.pop_front();
                    if (rsp.res_x !== e.x)
                    begin
                        $error("res_x exp %0d got %0d", e.x, rsp.res_x); fail_count++;
                    end
                    if (rsp.res_y !== e.y)
                    begin
                        $error("res_y exp %0d got %0d", e.y, rsp.res_y); fail_count++;
                    end
                    if (rsp.res_z !== e.z)
                    begin
                        $error("res_z exp %0d got %0d", e.z, rsp.res_z); fail_count++;
                    end
                    if (rsp.res_w !== e.w)
                    begin
                        $error("res_w exp %0d got %0d", e.w, rsp.res_w); fail_count++;
                    end
                    if (rsp.renormalized !== e.renormalized)
                    begin
                        $error("renormalized exp %0b got %0b", e.renormalized,
                               rsp.renormalized);
                        fail_count++;
                    end
                    if (rsp.zero_norm !== e.zero_norm)
                    begin
                        $error("zero_norm exp %0b got %0b", e.zero_norm, rsp.zero_norm);
                        fail_count++;
                    end
                    if (rsp.saturated !== e.saturated)
                    begin
                        $error("saturated exp %0b got %0b", e.saturated, rsp.saturated);
                        fail_count++;
                    end
                end
            end
        end
    end

endmodule

@@ dv/tb_quaternion_compose_renorm_top.sv @@
// Testbench top: clock, reset, request and register stimulus, final verdict.
module tb_quaternion_compose_renorm_top;
    import qcr_pkg::*;

    localparam logic signed [COMP_WIDTH-1:0] ONE_Q = 32'sd1 <<< FRAC_BITS;
    localparam logic signed [COMP_WIDTH-1:0] MAXC  = 32'h7FFF_FFFF;
    localparam logic signed [COMP_WIDTH-1:0] MINC  = 32'h8000_0000;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CNT_WIDTH-1:0] cfg_wdata = '0;
    logic                 calm = 1'b0;
    int                   fail_count;
    int                   pending;

    qcr_cmd_if cmd ();
    qcr_rsp_if rsp ();

    quaternion_compose_renorm_top uut (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .rsp(rsp),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
    );

    qcr_checker chk (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .rsp(rsp), .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata), .fail_count(fail_count), .pending(pending)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Stall the response side in random bursts, none once calm.
    always @(posedge clk)
    begin
        if (!rst_n)
            rsp.ready <= 1'b0;
        else if (calm || $urandom_range(3) != 0)
            rsp.ready <= 1'b1;
        else
        begin
            rsp.ready <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge clk);
            rsp.ready <= 1'b1;
        end
    end

    // Random component: mostly near unit scale, sometimes any bit pattern, a tiny value or an extreme.
    function automatic logic signed [COMP_WIDTH-1:0] rand_comp();
        case ($urandom_range(9))
            0:       return $urandom;
            1:       return $urandom_range(1) ? MAXC : MINC;
            2:       return $signed(32'($urandom_range(15))) - 8;
            default: return $signed(32'($urandom_range(2 * ONE_Q))) - ONE_Q;
        endcase
    endfunction

    // Send one request and wait for it to be taken; valid stays up for the next one.
    task automatic send_request(input logic [MODE_WIDTH-1:0] m,
        input logic signed [COMP_WIDTH-1:0] x, input logic signed [COMP_WIDTH-1:0] y,
        input logic signed [COMP_WIDTH-1:0] z, input logic signed [COMP_WIDTH-1:0] w);
        if (!calm && $urandom_range(3) == 0)
        begin
            cmd.valid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge clk);
        end
        cmd.valid <= 1'b1;
        cmd.mode  <= m;
        cmd.arg_x <= x;
        cmd.arg_y <= y;
        cmd.arg_z <= z;
        cmd.arg_w <= w;
        do @(posedge clk); while (!cmd.ready);
    endtask

    task automatic send_random(input logic [MODE_WIDTH-1:0] m);
        send_request(m, rand_comp(), rand_comp(), rand_comp(), rand_comp());
    endtask

    // Drop valid, drain, then write the renorm interval while idle.
    task automatic set_interval(input logic [CNT_WIDTH-1:0] v);
        cmd.valid <= 1'b0;
        repeat (2) @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    initial
    begin
        logic [CNT_WIDTH-1:0] settings [5];
        settings = '{10'd0, 10'd1023, 10'd3, 10'd1, 10'd17};
        cmd.valid = 1'b0;
        cmd.mode  = MODE_LOAD;
        cmd.arg_x = '0;
        cmd.arg_y = '0;
        cmd.arg_z = '0;
        cmd.arg_w = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: normalize/compose on zero, extremes, every mode.
        send_request(MODE_NORM, 0, 0, 0, 0);
        send_request(MODE_PRE, ONE_Q, 0, 0, ONE_Q);
        send_request(MODE_LOAD, 0, 0, 0, ONE_Q);
        send_request(MODE_POST, 0, ONE_Q, 0, 0);
        send_request(MODE_NORM, 0, 0, 0, 0);
        send_request(MODE_LOAD, MAXC, MAXC, MAXC, MAXC);
        send_request(MODE_POST, MINC, MINC, MINC, MINC);
        send_request(MODE_PRE, MAXC, MINC, MAXC, MINC);
        send_request(MODE_NORM, 0, 0, 0, 0);
        send_request(MODE_LOAD, 1, 0, -1, 0);
        send_request(MODE_NORM, 0, 0, 0, 0);
        send_request(MODE_LOAD, MINC, 0, 0, 0);
        send_request(MODE_NORM, 0, 0, 0, 0);
        send_request(MODE_LOAD, -1, -1, -1, -1);
        send_request(MODE_POST, 32'h5555_5555, 32'hAAAA_AAAA, 1, -1);
        send_request(MODE_NORM, 0, 0, 0, 0);

        // Random phases under several intervals, the extremes among them.
        for (int ph = 0; ph < 6; ph++)
        begin
            if (ph > 0) set_interval(settings[ph-1]);
            if (ph == 5) calm = 1'b1;
            for (int n = 0; n < 230; n++)
            begin
                case ($urandom_range(9))
                    0:       send_random(MODE_LOAD);
                    1:       send_random(MODE_NORM);
                    2, 3:    send_random(MODE_POST);
                    default: send_random(MODE_PRE);
                endcase
            end
        end

        cmd.valid <= 1'b0;
        repeat (2) @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (400) @(posedge clk);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        #10000000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
